// ----- rtl/pfc_pkg.sv -----
// Shared types, constants and square-geometry helpers for the Playfair digraph cipher.
package pfc_pkg;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] pos_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_A   = 5'd0;
    localparam letter_t LETTER_I   = 5'd8;
    localparam letter_t LETTER_J   = 5'd9;
    localparam letter_t LETTER_X   = 5'd23;
    localparam letter_t NUM_LETTERS = 5'd26;
    localparam pos_t    NUM_CELLS   = 5'd25;
    localparam coord_t  SIDE_MAX    = 3'd4;

    // command queue depth, at least 2
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // same encoding as the opcode field on the input stream
    typedef enum logic [1:0] {
        CMD_KEY  = 2'd0,
        CMD_DONE = 2'd1,
        CMD_TEXT = 2'd2,
        CMD_END  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        letter_t   letter;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS,
        ST_CELL,
        ST_OUT
    } back_state_t;

    function automatic letter_t filler_for(input letter_t l);
        return (l == LETTER_X) ? LETTER_A : LETTER_X;
    endfunction

    // row of a square position (0..24)
    function automatic coord_t pos_row(input pos_t p);
        coord_t r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic coord_t pos_col(input pos_t p);
        pos_t base;
        coord_t r;
        r    = pos_row(p);
        base = ({2'b00, r} << 2) + {2'b00, r};
        return coord_t'(p - base);
    endfunction

    function automatic pos_t cell_addr(input coord_t r, input coord_t c);
        return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    endfunction

    // one step along a row or column with wraparound; back moves up/left
    function automatic coord_t coord_step(input coord_t v, input logic back);
        coord_t n;
        if (back) n = (v == 3'd0) ? SIDE_MAX : v - 3'd1;
        else      n = (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
        return n;
    endfunction

endpackage

// ----- rtl/pfc_front.sv -----
// Front end: classifies input beats and queues commands for the back end.
module pfc_front import pfc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    letter_t   letter_in;
    letter_t   letter_map;
    cmd_kind_t kind_in;
    logic      keep;
    logic      push;
    logic      pop;
    cmd_t      cmd_in;

    // J folds onto I; key or text letters past Z are dropped here
    always_comb begin
        letter_in  = s_tdata[4:0];
        letter_map = (letter_in == LETTER_J) ? LETTER_I : letter_in;
        kind_in    = cmd_kind_t'(s_tuser);
        keep       = !(((kind_in == CMD_KEY) || (kind_in == CMD_TEXT)) &&
                       (letter_map >= NUM_LETTERS));
        cmd_in     = '{kind: kind_in, letter: letter_map};
    end

    assign s_tready  = (count_reg != CNT_FULL);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- rtl/pfc_back.sv -----
// Back end: builds the key square, pairs text letters and emits digraph beats.
module pfc_back import pfc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    // key square and its inverse, two registered read ports each
    letter_t key_square [NUM_CELLS];
    pos_t    letter_pos [NUM_LETTERS];

    back_state_t state_reg, state_next;
    logic [25:0] used_reg, used_next;
    pos_t        fill_reg, fill_next;
    logic        ready_reg, ready_next;
    letter_t     pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    letter_t     fill_idx_reg, fill_idx_next;
    logic        decrypt_mode_reg;
    letter_t     a_reg, a_next;
    letter_t     b_reg, b_next;
    logic [1:0]  obuf_cnt_reg, obuf_cnt_next;
    letter_t     obuf0_reg, obuf1_reg;
    logic        obuf_load;

    pos_t    pos_a_q, pos_b_q;
    pos_t    cell_addr_a, cell_addr_b;
    letter_t cell_a_q, cell_b_q;

    logic    place_en;
    letter_t place_letter;
    pos_t    place_at;

    coord_t ra, ca, rb, cb;
    coord_t ra_o, ca_o, rb_o, cb_o;

    assign cmd_ready = (state_reg == ST_IDLE);

    // pair geometry from the registered positions
    always_comb begin
        ra   = pos_row(pos_a_q);
        ca   = pos_col(pos_a_q);
        rb   = pos_row(pos_b_q);
        cb   = pos_col(pos_b_q);
        ra_o = ra;
        ca_o = ca;
        rb_o = rb;
        cb_o = cb;
        if (ca == cb) begin
            ra_o = coord_step(ra, decrypt_mode_reg);
            rb_o = coord_step(rb, decrypt_mode_reg);
        end else if (ra == rb) begin
            ca_o = coord_step(ca, decrypt_mode_reg);
            cb_o = coord_step(cb, decrypt_mode_reg);
        end else begin
            ca_o = cb;
            cb_o = ca;
        end
        cell_addr_a = cell_addr(ra_o, ca_o);
        cell_addr_b = cell_addr(rb_o, cb_o);
    end

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        fill_next       = fill_reg;
        ready_next      = ready_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        fill_idx_next   = fill_idx_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        place_en        = 1'b0;
        place_letter    = cmd.letter;
        place_at        = fill_reg;
        obuf_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_KEY: begin
                            // a key letter after a finished square starts a new key
                            if (ready_reg) begin
                                used_next       = '0;
                                fill_next       = '0;
                                ready_next      = 1'b0;
                                pend_valid_next = 1'b0;
                                place_at        = '0;
                            end
                            if (!used_next[cmd.letter] && (place_at < NUM_CELLS)) begin
                                place_en                = 1'b1;
                                used_next[cmd.letter]   = 1'b1;
                                fill_next               = place_at + 1'b1;
                            end
                        end
                        CMD_DONE: begin
                            fill_idx_next = '0;
                            state_next    = ST_FILL;
                        end
                        CMD_TEXT: begin
                            if (ready_reg) begin
                                if (!pend_valid_reg) begin
                                    pend_next       = cmd.letter;
                                    pend_valid_next = 1'b1;
                                end else if (!decrypt_mode_reg &&
                                             (pend_reg == cmd.letter)) begin
                                    // doubled letter: pad, repeat starts next pair
                                    a_next     = pend_reg;
                                    b_next     = filler_for(pend_reg);
                                    state_next = ST_POS;
                                end else begin
                                    a_next          = pend_reg;
                                    b_next          = cmd.letter;
                                    pend_valid_next = 1'b0;
                                    state_next      = ST_POS;
                                end
                            end
                        end
                        default: begin
                            if (pend_valid_reg && ready_reg && !decrypt_mode_reg) begin
                                a_next     = pend_reg;
                                b_next     = filler_for(pend_reg);
                                state_next = ST_POS;
                            end
                            pend_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                place_letter = fill_idx_reg;
                if ((fill_reg == NUM_CELLS) || (fill_idx_reg == NUM_LETTERS)) begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    if ((fill_idx_reg != LETTER_J) && !used_reg[fill_idx_reg]) begin
                        place_en                = 1'b1;
                        used_next[fill_idx_reg] = 1'b1;
                        fill_next               = fill_reg + 1'b1;
                    end
                    fill_idx_next = fill_idx_reg + 1'b1;
                end
            end
            ST_POS: begin
                state_next = ST_CELL;
            end
            ST_CELL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (obuf_cnt_reg == 2'd0) begin
                    obuf_load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // two-beat output buffer: first letter then second with tlast
    always_comb begin
        obuf_cnt_next = obuf_cnt_reg;
        if (obuf_load) begin
            obuf_cnt_next = 2'd2;
        end else if (m_tvalid && m_tready) begin
            obuf_cnt_next = obuf_cnt_reg - 2'd1;
        end
    end

    assign m_tvalid = (obuf_cnt_reg != 2'd0);
    assign m_tlast  = (obuf_cnt_reg == 2'd1);
    assign m_tdata  = {3'b000, (obuf_cnt_reg == 2'd2) ? obuf0_reg : obuf1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            used_reg         <= '0;
            fill_reg         <= '0;
            ready_reg        <= 1'b0;
            pend_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            fill_idx_reg     <= '0;
            decrypt_mode_reg <= 1'b0;
            obuf_cnt_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            ready_reg      <= ready_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            fill_idx_reg   <= fill_idx_next;
            obuf_cnt_reg   <= obuf_cnt_next;
            if (cfg_we) begin
                decrypt_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (obuf_load) begin
            obuf0_reg <= cell_a_q;
            obuf1_reg <= cell_b_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (place_en) begin
            key_square[place_at]     <= place_letter;
            letter_pos[place_letter] <= place_at;
        end
        pos_a_q  <= letter_pos[a_reg];
        pos_b_q  <= letter_pos[b_reg];
        cell_a_q <= key_square[cell_addr_a];
        cell_b_q <= key_square[cell_addr_b];
    end

endmodule

// ----- rtl/playfair_digraph_cipher_top.sv -----
// Top level of the Playfair digraph cipher: front classifier, command queue, cipher engine.
// Throughput: one input beat a cycle into the command queue while it has a free slot. The engine
// handles a key letter, or a text letter that completes no pair, in its idle state; a completed
// pair runs through position lookup, cell lookup and output load, and a key-done beat walks the
// alphabet. Each pair leaves as two output beats. A pair-completing beat passes the queue, the
// pair registers, the registered letter-position and square-cell lookups and the output buffer.
// Reset (aresetn low, synchronous): queue empty, square not ready, used map and fill count clear.
module playfair_digraph_cipher_top import pfc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT   // command queue depth, 2 or more
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: decrypt_mode (0 encrypt, 1 decrypt)
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [4:0] letter, [7:5] zero
    input  logic [1:0] s_tuser,    // [1:0] opcode
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [4:0] out_letter, [7:5] zero
    output logic       m_tlast     // pair_end: second letter of a digraph
);

    // front to back command beat
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Front: J folded to I, out-of-range letters dropped, commands queued so the
    // input side keeps taking beats while the engine is busy, until the queue is full.
    pfc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: square build, pairing, rule lookup and a two-beat output buffer that
    // lets the next command start while the previous pair drains.
    pfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the Playfair digraph cipher top level.
module tb;
    import pfc_pkg::*;

    // Receiver hold-off for the pressure test, and the settle time after the last
    // expected beat before the mode register may be touched: queue slots plus the
    // key-done alphabet walk.
    localparam int LONG_HOLD      = 400;
    localparam int ENGINE_SETTLE  = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BEATS   = 1200;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [4:0] letter, [7:5] zero
    logic [1:0] s_tuser;     // [1:0] opcode
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [4:0] out_letter, [7:5] zero
    logic       m_tlast;     // pair_end

    // Predictor state: the square, where each letter sits, which letters are used,
    // how far the fill has got, and the letter waiting for its partner.
    logic [4:0] sq_cell  [0:24];
    logic [4:0] where_is [0:25];
    bit         placed   [0:25];
    int         n_placed    = 0;
    bit         sq_ready    = 1'b0;
    logic [4:0] held_letter = '0;
    bit         held_valid  = 1'b0;
    bit         mode_dec    = 1'b0;

    out_beat_t  expected_beats[$];
    int         err_count    = 0;
    int         beats_sent   = 0;
    int         idle_cycles  = 0;
    bit         quiet        = 1'b0;   // no gaps on either side while set
    bit         long_hold    = 1'b0;   // receiver picks this up and holds off

    playfair_digraph_cipher_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [4:0] pad_for(input logic [4:0] l);
        return (l == LETTER_X) ? LETTER_A : LETTER_X;
    endfunction

    function void place_in_square(input logic [4:0] l);
        if (!placed[l] && n_placed < 25) begin
            sq_cell[n_placed] = l;
            where_is[l]       = 5'(n_placed);
            placed[l]         = 1'b1;
            n_placed++;
        end
    endfunction

    // Column rule first, then row rule, else rectangle; decrypt steps forward by 4 mod 5, that is back by one.
    function void emit_digraph(input logic [4:0] a, input logic [4:0] b);
        int        pa, pb, ra, ca, rb, cb, step;
        out_beat_t beat;
        logic [4:0] oa, ob;
        pa   = where_is[a];
        pb   = where_is[b];
        ra   = pa / 5;
        ca   = pa % 5;
        rb   = pb / 5;
        cb   = pb % 5;
        step = mode_dec ? 4 : 1;
        if (ca == cb) begin
            oa = sq_cell[((ra + step) % 5) * 5 + ca];
            ob = sq_cell[((rb + step) % 5) * 5 + cb];
        end else if (ra == rb) begin
            oa = sq_cell[ra * 5 + (ca + step) % 5];
            ob = sq_cell[rb * 5 + (cb + step) % 5];
        end else begin
            oa = sq_cell[ra * 5 + cb];
            ob = sq_cell[rb * 5 + ca];
        end
        beat.data = {3'b000, oa};
        beat.last = 1'b0;
        expected_beats.push_back(beat);
        beat.data = {3'b000, ob};
        beat.last = 1'b1;
        expected_beats.push_back(beat);
    endfunction

    function void cipher_accept(input cmd_kind_t kind, input logic [4:0] raw);
        logic [4:0] l;
        l = (raw == LETTER_J) ? LETTER_I : raw;
        case (kind)
            CMD_KEY: begin
                if (l < NUM_LETTERS) begin
                    // a key letter after a finished square starts a fresh key
                    if (sq_ready) begin
                        foreach (placed[i]) placed[i] = 1'b0;
                        n_placed   = 0;
                        sq_ready   = 1'b0;
                        held_valid = 1'b0;
                    end
                    place_in_square(l);
                end
            end
            CMD_DONE: begin
                for (int i = 0; i < 26; i++)
                    if (i != LETTER_J) place_in_square(5'(i));
                sq_ready = 1'b1;
            end
            CMD_TEXT: begin
                if (sq_ready && l < NUM_LETTERS) begin
                    if (!held_valid) begin
                        held_letter = l;
                        held_valid  = 1'b1;
                    end else if (!mode_dec && held_letter == l) begin
                        // doubled letter: pad, the repeat opens the next pair
                        emit_digraph(l, pad_for(l));
                    end else begin
                        held_valid = 1'b0;
                        emit_digraph(held_letter, l);
                    end
                end
            end
            default: begin
                if (held_valid && sq_ready && !mode_dec)
                    emit_digraph(held_letter, pad_for(held_letter));
                held_valid = 1'b0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // Mostly no gap, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [4:0] rand_letter();
        if ($urandom_range(0, 99) < 6) return 5'($urandom_range(26, 31));
        return 5'($urandom_range(0, 25));
    endfunction

    // valid is held high from one beat to the next when there is no gap
    task automatic send_beat(input cmd_kind_t kind, input logic [4:0] letter);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, letter};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cipher_accept(kind, letter);
        beats_sent++;
    endtask

    // Everything out, then let the engine finish any walk that gives no beats.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (ENGINE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_mode(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_dec   = v;
    endtask

    // Receiver: random stalls, or one long hold-off when asked.
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                int unsigned n;
                n = pick_gap();
                if (n != 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: out_letter %0d pair_end %0b", m_tdata, m_tlast);
                err_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_letter: expected %0d, got %0d", want.data, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("pair_end: expected %0b, got %0b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: any stretch with no beat on either side longer than the limit is a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[playfair_digraph_cipher_top] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Key J,E,I,X gives rows IEXAB / CDFGH / KLMNO / PQRST / UVWYZ.
    task automatic test_encrypt_directed();
        send_beat(CMD_TEXT, 5'd0);          // no square yet: dropped
        send_beat(CMD_END, 5'd0);
        send_beat(CMD_KEY, LETTER_J);       // placed as I
        send_beat(CMD_KEY, 5'd26);          // out of range
        send_beat(CMD_KEY, 5'd4);
        send_beat(CMD_KEY, LETTER_I);       // repeat of the J
        send_beat(CMD_KEY, LETTER_X);
        send_beat(CMD_TEXT, 5'd2);          // square still incomplete
        send_beat(CMD_DONE, 5'd0);
        send_beat(CMD_DONE, 5'd0);          // already full
        send_beat(CMD_TEXT, LETTER_X);
        send_beat(CMD_TEXT, LETTER_X);      // doubled X pads with A
        send_beat(CMD_TEXT, 5'd31);         // out of range
        send_beat(CMD_TEXT, 5'd25);
        send_beat(CMD_TEXT, LETTER_J);
        send_beat(CMD_TEXT, LETTER_I);      // doubled via J
        send_beat(CMD_END, 5'd31);          // lone I padded
        send_beat(CMD_TEXT, 5'd0);
        send_beat(CMD_TEXT, 5'd1);
        send_beat(CMD_KEY, 5'd2);           // fresh key over a finished square
        send_beat(CMD_TEXT, 5'd3);          // dropped until key done
        send_beat(CMD_DONE, 5'd0);
    endtask

    task automatic test_decrypt_directed();
        drain_and_settle();
        write_mode(1'b1);
        send_beat(CMD_TEXT, 5'd4);
        send_beat(CMD_TEXT, 5'd4);          // doubled pair taken as is
        send_beat(CMD_TEXT, LETTER_X);
        send_beat(CMD_TEXT, 5'd0);
        send_beat(CMD_TEXT, 5'd5);
        send_beat(CMD_END, 5'd0);           // lone letter dropped
    endtask

    // One key, key done, a run of text, end of text, with some noise and breaks.
    task automatic run_session(input int unsigned text_len, input bit allow_noise);
        int unsigned style, n_key, r, i;
        int          j;
        logic [4:0]  perm [0:25];
        logic [4:0]  tmp, prev;
        style = $urandom_range(0, 9);
        if (style < 6) begin
            n_key = $urandom_range(1, 10);
            for (i = 0; i < n_key; i++) send_beat(CMD_KEY, rand_letter());
        end else if (style < 8) begin
            // whole alphabet: fills the square, the rest are ignored
            for (i = 0; i < 26; i++) perm[i] = 5'(i);
            for (j = 25; j > 0; j--) begin
                r       = $urandom_range(0, j);
                tmp     = perm[j];
                perm[j] = perm[r];
                perm[r] = tmp;
            end
            for (i = 0; i < 26; i++) send_beat(CMD_KEY, perm[i]);
            n_key = $urandom_range(0, 4);
            for (i = 0; i < n_key; i++) send_beat(CMD_KEY, rand_letter());
        end else if (style == 8) begin
            n_key = $urandom_range(11, 20);
            for (i = 0; i < n_key; i++) send_beat(CMD_KEY, rand_letter());
        end
        if ($urandom_range(0, 9) != 0) send_beat(CMD_DONE, rand_letter());
        if ($urandom_range(0, 9) == 0) send_beat(CMD_DONE, rand_letter());
        prev = 5'd0;
        for (i = 0; i < text_len; i++) begin
            if (allow_noise && $urandom_range(0, 99) < 6)
                send_beat(cmd_kind_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
            r = $urandom_range(0, 99);
            if (r < 20)      tmp = prev;
            else if (r < 30) tmp = LETTER_X;
            else if (r < 35) tmp = LETTER_J;
            else             tmp = rand_letter();
            send_beat(CMD_TEXT, tmp);
            prev = tmp;
        end
        if ($urandom_range(0, 9) != 0) send_beat(CMD_END, rand_letter());
    endtask

    // Receiver holds off while the sender keeps offering: queue fills, input stalls.
    task automatic test_backpressure();
        drain_and_settle();
        write_mode(1'b0);
        quiet     = 1'b1;
        long_hold = 1'b1;
        run_session(60, 1'b0);
        quiet     = 1'b0;
    endtask

    task automatic test_random();
        int start;
        start = beats_sent;
        while (beats_sent < start + RANDOM_BEATS) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_and_settle();
                write_mode(!mode_dec);
            end
            quiet = ($urandom_range(0, 7) == 0);
            run_session($urandom_range(0, 30), 1'b1);
        end
        quiet = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_KEY;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b0);

        test_encrypt_directed();
        test_decrypt_directed();
        test_backpressure();
        test_random();

        drain_and_settle();
        if (err_count == 0)
            $display("[playfair_digraph_cipher_top] OK");
        else
            $display("[playfair_digraph_cipher_top] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pfc_pkg.sv
rtl/pfc_front.sv
rtl/pfc_back.sv
rtl/playfair_digraph_cipher_top.sv
verif/tb.sv
